[rtl/core/qptti_pkg.sv]
// Shared primitive codes and types for the quad/line-loop index decomposer.
package qptti_pkg;

  typedef logic [3:0] prim_t;

  localparam prim_t MODE_LINE_LOOP  = 4'd2;
  localparam prim_t MODE_QUADS      = 4'd7;
  localparam prim_t MODE_QUAD_STRIP = 4'd8;
  localparam prim_t HW_LINE_STRIP   = 4'd3;
  localparam prim_t HW_TRIANGLES    = 4'd4;

  localparam int MAX_RESULTS = 6;
  localparam int POS_W       = 3;
  localparam int DATA_W      = 32;
  localparam int OUT_USER_W  = 6;

  typedef logic [POS_W-1:0] pos_t;

  // Bit positions inside out_tuser.
  localparam int USER_PRIM_LSB = 0;
  localparam int USER_CHANGED  = 4;
  localparam int USER_DRAW_END = 5;

endpackage

[rtl/core/quad_primitive_to_triangle_indices_top.sv]
// Top level: rewrites quad, quad-strip and line-loop index streams for triangle hardware.
//
// Vertex indices of one draw enter one item per cycle while in_tready is high, under the
// configured primitive mode, and leave as hardware indices one item per cycle, unless
// out_tready holds them, from an output register. An input item that causes k results
// (one for pass-through and line strips, three for the closing vertex of a line loop,
// six for a completed quad or quad-strip pair) keeps the result sequencer busy until
// the last of them is out; the next input item is taken in the cycle the last of those
// results moves into the output register. Items that cause no result do not occupy the
// sequencer. Each result passes through the job register and then the output register.
// The mode is written through cfg_wr_en and cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce.
module quad_primitive_to_triangle_indices_top
  import qptti_pkg::*;
#(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [3:0]            cfg_wr_data,   // primitive_mode
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,      // [31:0] vertex_index
  input  logic                  in_tlast,      // last_vertex
  input  logic [0:0]            in_tuser,      // [0] first_vertex
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,     // [31:0] out_index
  output logic                  out_tlast,     // run_last
  output logic [OUT_USER_W-1:0] out_tuser      // [3:0] out_prim, [4] prim_changed,
                                               // [5] draw_end
);

  typedef logic [INDEX_WIDTH-1:0] idx_t;

  // Draw state.
  prim_t mode_r;
  prim_t cur_hw_r;
  logic [1:0] phase_r, phase_nxt;
  logic spr_r, spr_nxt;
  idx_t held_a_r, held_a_nxt;
  idx_t held_b_r, held_b_nxt;
  idx_t held_c_r, held_c_nxt;
  idx_t start_r, start_nxt;

  // Pending results of one input item.
  logic                   job_v_r;
  idx_t                   job_idx_r [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] job_end_r;
  pos_t                   job_last_r;
  pos_t                   job_pos_r;
  prim_t                  job_hw_r;
  logic                   job_chg_r;

  // Output register.
  logic                  out_valid_r;
  logic [DATA_W-1:0]     out_data_r;
  logic                  out_last_r;
  logic [OUT_USER_W-1:0] out_user_r;

  // Decode of the incoming item.
  idx_t                   v;
  logic                   first, last;
  logic [1:0]             phase_eff;
  logic                   spr_eff;
  idx_t                   new_idx [MAX_RESULTS];
  logic [MAX_RESULTS-1:0] new_end;
  pos_t                   new_last;
  logic                   new_any;
  prim_t                  new_hw;

  logic in_acc, load_out, job_done;

  assign v         = in_tdata[INDEX_WIDTH-1:0];
  assign first     = in_tuser[0];
  assign last      = in_tlast;
  assign phase_eff = first ? 2'd0 : phase_r;
  assign spr_eff   = first ? 1'b0 : spr_r;

  always_comb begin
    held_a_nxt = held_a_r;
    held_b_nxt = held_b_r;
    held_c_nxt = held_c_r;
    phase_nxt  = phase_eff;
    spr_nxt    = spr_eff;
    start_nxt  = first ? v : start_r;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      new_idx[i] = v;
    end
    new_end  = '0;
    new_last = '0;
    new_any  = 1'b0;
    new_hw   = mode_r;

    case (mode_r)
      MODE_LINE_LOOP: begin
        new_hw     = HW_LINE_STRIP;
        new_any    = 1'b1;
        new_end[0] = last;
        if (last) begin
          // Closing segment back to the first index of the loop.
          new_idx[2] = start_nxt;
          new_end[2] = 1'b1;
          new_last   = pos_t'(2);
        end
      end
      MODE_QUADS: begin
        new_hw = HW_TRIANGLES;
        case (phase_eff)
          2'd0: begin held_a_nxt = v; phase_nxt = 2'd1; end
          2'd1: begin held_b_nxt = v; phase_nxt = 2'd2; end
          2'd2: begin held_c_nxt = v; phase_nxt = 2'd3; end
          default: begin
            new_any    = 1'b1;
            new_idx[0] = held_a_r;
            new_idx[1] = held_b_r;
            new_idx[3] = held_b_r;
            new_idx[4] = held_c_r;
            new_end[5] = last;
            new_last   = pos_t'(MAX_RESULTS - 1);
            phase_nxt  = 2'd0;
          end
        endcase
      end
      MODE_QUAD_STRIP: begin
        new_hw = HW_TRIANGLES;
        if (!phase_eff[0]) begin
          if (spr_eff) begin
            held_c_nxt = v;
          end else begin
            held_a_nxt = v;
          end
          phase_nxt = 2'd1;
        end else begin
          if (spr_eff) begin
            new_any    = 1'b1;
            new_idx[0] = held_a_r;
            new_idx[1] = held_b_r;
            new_idx[3] = held_c_r;
            new_idx[4] = held_a_r;
            new_end[5] = last;
            new_last   = pos_t'(MAX_RESULTS - 1);
            held_a_nxt = held_c_r;
          end
          held_b_nxt = v;
          spr_nxt    = 1'b1;
          phase_nxt  = 2'd0;
        end
      end
      default: begin
        new_any    = 1'b1;
        new_end[0] = last;
      end
    endcase

    if (last) begin
      phase_nxt = 2'd0;
      spr_nxt   = 1'b0;
    end
  end

  assign load_out  = job_v_r && (!out_valid_r || out_tready);
  assign job_done  = load_out && (job_pos_r == job_last_r);
  assign in_tready = !job_v_r || job_done;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= HW_TRIANGLES;
      cur_hw_r <= HW_TRIANGLES;
      phase_r  <= 2'd0;
      spr_r    <= 1'b0;
      held_a_r <= '0;
      held_b_r <= '0;
      held_c_r <= '0;
      start_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_acc) begin
        phase_r  <= phase_nxt;
        spr_r    <= spr_nxt;
        held_a_r <= held_a_nxt;
        held_b_r <= held_b_nxt;
        held_c_r <= held_c_nxt;
        start_r  <= start_nxt;
        if (new_any) begin
          cur_hw_r <= new_hw;
        end
      end
    end
  end

  // Result sequencer: walks the pending results of one input item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r   <= 1'b0;
      job_pos_r <= '0;
    end else if (in_acc && new_any) begin
      job_v_r   <= 1'b1;
      job_pos_r <= '0;
    end else if (job_done) begin
      job_v_r <= 1'b0;
    end else if (load_out) begin
      job_pos_r <= job_pos_r + pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && new_any) begin
      job_idx_r  <= new_idx;
      job_end_r  <= new_end;
      job_last_r <= new_last;
      job_hw_r   <= new_hw;
      job_chg_r  <= (new_hw != cur_hw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= DATA_W'(job_idx_r[job_pos_r]);
      out_last_r <= (job_pos_r == job_last_r);
      out_user_r[USER_PRIM_LSB +: 4] <= job_hw_r;
      // All results of one item share a primitive, so only the first can flag a change.
      out_user_r[USER_CHANGED]       <= job_chg_r && (job_pos_r == '0);
      out_user_r[USER_DRAW_END]      <= job_end_r[job_pos_r];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/core/qptti_checker.sv]
// Port-level checker for the index decomposer, bound to the top level.
module qptti_checker
  import qptti_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic                  out_tlast,
  input logic [OUT_USER_W-1:0] out_tuser
);

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // No result is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // A triangle draw ends only on the last result of its input item.
  a_tri_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USER_DRAW_END] &&
    (out_tuser[USER_PRIM_LSB +: 4] == HW_TRIANGLES) |-> out_tlast)
    else $error("triangle draw_end not on the last result of its item");

  // A result that is not the last of its item is followed by one of the same primitive.
  a_same_prim: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
    !out_tvalid || (!out_tuser[USER_CHANGED] &&
    (out_tuser[USER_PRIM_LSB +: 4] == $past(out_tuser[USER_PRIM_LSB +: 4]))))
    else $error("primitive changed inside the results of one item");

endmodule

bind quad_primitive_to_triangle_indices_top qptti_checker u_qptti_checker (.*);

[sim/tb_quad_primitive_to_triangle_indices_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the quad, quad-strip and line-loop index decomposer.
module tb_quad_primitive_to_triangle_indices_top;
  import qptti_pkg::*;

  // Primitive codes that only pass through, used at the extremes of the mode field.
  localparam prim_t MODE_POINTS   = 4'd0;
  localparam prim_t MODE_TOP_CODE = 4'd15;

  localparam int NUM_VEC       = 30;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 80;
  localparam int PHASE_ITEMS   = 18;

  typedef struct packed {
    logic [DATA_W-1:0] index;
    prim_t             prim;
    logic              changed;
    logic              draw_end;
    logic              run_last;
  } hw_index_t;

  typedef struct packed {
    bit          is_cfg;
    prim_t       mode;
    logic [31:0] index;
    bit          first;
    bit          last;
    bit          typed;
    logic [31:0] e_index;
    prim_t       e_prim;
    bit          e_changed;
    bit          e_end;
  } vec_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [3:0]            cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;
  logic                  out_tlast;
  logic [OUT_USER_W-1:0] out_tuser;

  always #2 clk = ~clk;

  quad_primitive_to_triangle_indices_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  hw_index_t expected_hw_indices[$];
  hw_index_t step_res [0:MAX_RESULTS-1];
  int        step_count;

  // Predictor state.
  prim_t       mode_reg = HW_TRIANGLES;
  prim_t       last_hw_prim = HW_TRIANGLES;
  logic [1:0]  quad_pos = '0;
  logic [31:0] vert_a = '0;
  logic [31:0] vert_b = '0;
  logic [31:0] vert_c = '0;
  logic [31:0] loop_origin = '0;
  bit          strip_primed = 1'b0;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mode_writes = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  vec_row_t vectors [0:NUM_VEC-1];

  function automatic void emit(prim_t hw, logic [31:0] idx, bit ends_draw);
    step_res[step_count] = '{index: idx, prim: hw, changed: (hw != last_hw_prim),
                             draw_end: ends_draw, run_last: 1'b0};
    last_hw_prim = hw;
    step_count++;
  endfunction

  function automatic void emit_pair_triangles(logic [31:0] p0, logic [31:0] p1,
                                              logic [31:0] p2, logic [31:0] p3,
                                              logic [31:0] p4, logic [31:0] p5,
                                              bit ends_draw);
    emit(HW_TRIANGLES, p0, 1'b0);
    emit(HW_TRIANGLES, p1, 1'b0);
    emit(HW_TRIANGLES, p2, 1'b0);
    emit(HW_TRIANGLES, p3, 1'b0);
    emit(HW_TRIANGLES, p4, 1'b0);
    emit(HW_TRIANGLES, p5, ends_draw);
  endfunction

  // Works out the hardware indices that one accepted vertex causes.
  function automatic void assemble_vertex(logic [31:0] idx, bit first, bit last);
    step_count = 0;
    if (first) begin
      quad_pos = '0;
      strip_primed = 1'b0;
      loop_origin = idx;
    end
    case (mode_reg)
      MODE_LINE_LOOP: begin
        emit(HW_LINE_STRIP, idx, last);
        if (last) begin
          emit(HW_LINE_STRIP, idx, 1'b0);
          emit(HW_LINE_STRIP, loop_origin, 1'b1);
        end
      end
      MODE_QUADS: begin
        case (quad_pos)
          2'd0: begin
            vert_a = idx;
            quad_pos = 2'd1;
          end
          2'd1: begin
            vert_b = idx;
            quad_pos = 2'd2;
          end
          2'd2: begin
            vert_c = idx;
            quad_pos = 2'd3;
          end
          default: begin
            emit_pair_triangles(vert_a, vert_b, idx, vert_b, vert_c, idx, last);
            quad_pos = 2'd0;
          end
        endcase
      end
      MODE_QUAD_STRIP: begin
        // Only the low bit of the group position matters for strips.
        if (!quad_pos[0]) begin
          if (strip_primed) vert_c = idx;
          else vert_a = idx;
          quad_pos = 2'd1;
        end else begin
          if (strip_primed) begin
            emit_pair_triangles(vert_a, vert_b, idx, vert_c, vert_a, idx, last);
            vert_a = vert_c;
          end
          vert_b = idx;
          strip_primed = 1'b1;
          quad_pos = 2'd0;
        end
      end
      default: emit(mode_reg, idx, last);
    endcase
    if (last) begin
      quad_pos = '0;
      strip_primed = 1'b0;
    end
    if (step_count > 0) step_res[step_count-1].run_last = 1'b1;
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_hw_indices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input prim_t mode);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    mode_reg = mode;
    mode_writes++;
  endtask

  task automatic send_vertex(input logic [31:0] idx, input bit first, input bit last,
                             input bit typed, input hw_index_t typed_res);
    int k;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= idx;
    in_tlast  <= last;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    assemble_vertex(idx, first, last);
    if (typed) begin
      expected_hw_indices.push_back(typed_res);
    end else begin
      for (k = 0; k < step_count; k++) expected_hw_indices.push_back(step_res[k]);
    end
    items_sent++;
  endtask

  // One draw with random content; stray marks now and then act as noise.
  task automatic random_draw(input int len);
    logic [31:0] base;
    bit          consec;
    bit          mark_first;
    bit          mark_last;
    bit          first;
    bit          last;
    int          i;
    base       = $urandom;
    consec     = $urandom_range(1);
    mark_first = ($urandom_range(9) != 0);
    mark_last  = ($urandom_range(9) != 0);
    for (i = 0; i < len; i++) begin
      first = (mark_first && i == 0) || ($urandom_range(19) == 0);
      last  = (mark_last && i == len - 1) || ($urandom_range(19) == 0);
      send_vertex(consec ? base + i : $urandom, first, last, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    hw_index_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hw_indices.size() == 0) begin
        $error("unexpected result item: index %h user %h", out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_hw_indices.pop_front();
        if (out_tdata !== want.index) begin
          $error("out_index: expected %h, actual %h", want.index, out_tdata);
          errors++;
        end
        if (out_tuser[USER_PRIM_LSB +: 4] !== want.prim) begin
          $error("out_prim: expected %0d, actual %0d", want.prim, out_tuser[USER_PRIM_LSB +: 4]);
          errors++;
        end
        if (out_tuser[USER_CHANGED] !== want.changed) begin
          $error("prim_changed: expected %b, actual %b", want.changed, out_tuser[USER_CHANGED]);
          errors++;
        end
        if (out_tuser[USER_DRAW_END] !== want.draw_end) begin
          $error("draw_end: expected %b, actual %b", want.draw_end, out_tuser[USER_DRAW_END]);
          errors++;
        end
        if (out_tlast !== want.run_last) begin
          $error("run_last: expected %b, actual %b", want.run_last, out_tlast);
          errors++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    int       row;
    int       ph;
    int       len;
    int       phase_start;
    int       wait_cycles;
    prim_t    pick;
    vec_row_t v;

    vectors = '{
      '{0, HW_TRIANGLES, 32'h0, 1, 0, 1, 32'h0, HW_TRIANGLES, 0, 0},
      '{0, HW_TRIANGLES, 32'hFFFF_FFFF, 0, 1, 1, 32'hFFFF_FFFF, HW_TRIANGLES, 0, 1},
      '{1, MODE_TOP_CODE, 32'h0, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd5, 1, 1, 1, 32'd5, MODE_TOP_CODE, 1, 1},
      '{1, MODE_QUADS, 32'h0, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd10, 1, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd11, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd12, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd13, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd20, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd21, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd22, 0, 1, 0, 32'h0, MODE_POINTS, 0, 0},
      '{1, MODE_QUAD_STRIP, 32'h0, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd30, 1, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd31, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd32, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd33, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd34, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd35, 0, 1, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd40, 1, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd41, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd42, 0, 1, 0, 32'h0, MODE_POINTS, 0, 0},
      '{1, MODE_LINE_LOOP, 32'h0, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd50, 1, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd51, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd52, 0, 1, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd60, 1, 1, 0, 32'h0, MODE_POINTS, 0, 0},
      '{1, MODE_POINTS, 32'h0, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0},
      '{0, HW_TRIANGLES, 32'd7, 1, 1, 1, 32'd7, MODE_POINTS, 1, 1},
      '{1, MODE_QUADS, 32'h0, 0, 0, 0, 32'h0, MODE_POINTS, 0, 0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run right after reset so the reset mode is exercised first.
    for (row = 0; row < NUM_VEC; row++) begin
      v = vectors[row];
      if (v.is_cfg) begin
        write_mode(v.mode);
      end else begin
        send_vertex(v.index, v.first, v.last, v.typed,
                    '{index: v.e_index, prim: v.e_prim, changed: v.e_changed,
                      draw_end: v.e_end, run_last: 1'b1});
      end
    end

    // Long output hold-off while quads keep coming, so the input side backs up.
    wait_idle();
    @(posedge clk);
    hold_request = HOLD_CYCLES;
    for (row = 0; row < 16; row++) begin
      send_vertex($urandom, row % 8 == 0, row % 8 == 7, 1'b0, '0);
    end
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 52;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 52;
        end
        default: begin
          send_idle_pct = 23;
          stall_pct = 23;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // Half of the draws keep the mode, so state carries across unmarked draws.
        if ($urandom_range(1) != 0) begin
          case ($urandom_range(9))
            0, 1, 2: pick = MODE_QUADS;
            3, 4, 5: pick = MODE_QUAD_STRIP;
            6, 7:    pick = MODE_LINE_LOOP;
            default: pick = prim_t'($urandom_range(15));
          endcase
          write_mode(pick);
        end
        if ($urandom_range(3) != 0) begin
          case (mode_reg)
            MODE_QUADS:      len = 4 * $urandom_range(1, 3);
            MODE_QUAD_STRIP: len = 2 * $urandom_range(2, 5);
            MODE_LINE_LOOP:  len = $urandom_range(1, 6);
            default:         len = $urandom_range(1, 4);
          endcase
        end else begin
          len = $urandom_range(1, 9);
        end
        random_draw(len);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_cycles = 0;
    while (expected_hw_indices.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_hw_indices.size() != 0) begin
      $error("%0d expected result items never arrived", expected_hw_indices.size());
      errors++;
    end
    $display("summary: %0d vertex items sent, %0d result items checked, %0d mode writes",
             items_sent, results_checked, mode_writes);
    $display("summary: quads, quad strips, line loops, pass-through codes, idle/stall mixes");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[quad_primitive_to_triangle_indices_top.f]
rtl/core/qptti_pkg.sv
rtl/core/quad_primitive_to_triangle_indices_top.sv
rtl/core/qptti_checker.sv
sim/tb_quad_primitive_to_triangle_indices_top.sv
